[sv/bpfsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfsa_pkg
// types, codes, microcode table and bank arithmetic for the page allocator
// ----------------------------------------------------------------------------
package bpfsa_pkg;

  localparam int unsigned BankShift = 14;
  localparam int unsigned Slots     = 3;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_ALLOC  = 2'd2,
    CMD_RESIZE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOPAGE = 2'd1,
    ST_OVER   = 2'd2,
    ST_TOOBIG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_PROGRAM_BASE = 2'd0,
    CFG_MAP_BASE     = 2'd1,
    CFG_STASH_BYTES  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_HAVE,
    ACT_WANT,
    ACT_PLAN,
    ACT_TEST,
    ACT_OP,
    ACT_POPWR,
    ACT_FINISH
  } act_e;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_ACCEPT,
    JC_DONE,
    JC_PUSH,
    JC_OUT_BUSY
  } jcond_e;

  typedef struct packed {
    act_e       act;
    jcond_e     cond;
    logic [2:0] target;
  } uword_t;

  localparam logic [2:0] StepIdle   = 3'd0;
  localparam logic [2:0] StepTest   = 3'd4;
  localparam logic [2:0] StepFinish = 3'd7;

  // microprogram; a step that does not jump falls through, the last wraps to idle
  function automatic uword_t ucode(logic [2:0] step);
    uword_t w;
    unique case (step)
      3'd0:    w = '{act: ACT_IDLE,   cond: JC_NO_ACCEPT, target: StepIdle};
      3'd1:    w = '{act: ACT_HAVE,   cond: JC_NEVER,     target: StepIdle};
      3'd2:    w = '{act: ACT_WANT,   cond: JC_NEVER,     target: StepIdle};
      3'd3:    w = '{act: ACT_PLAN,   cond: JC_NEVER,     target: StepIdle};
      3'd4:    w = '{act: ACT_TEST,   cond: JC_DONE,      target: StepFinish};
      3'd5:    w = '{act: ACT_OP,     cond: JC_PUSH,      target: StepTest};
      3'd6:    w = '{act: ACT_POPWR,  cond: JC_ALWAYS,    target: StepTest};
      3'd7:    w = '{act: ACT_FINISH, cond: JC_OUT_BUSY,  target: StepFinish};
      default: w = '{act: ACT_IDLE,   cond: JC_NEVER,     target: StepIdle};
    endcase
    return w;
  endfunction

  // banks needed for a top address, 1 to 4
  function automatic logic [2:0] banks_for(logic [15:0] top, logic [11:0] stash,
                                           logic [15:0] base);
    logic [15:0] v;
    v = top + {4'd0, stash} - base - 16'd1;
    return {1'b0, v[15:BankShift]} + 3'd1;
  endfunction

endpackage
`default_nettype wire

[sv/bank_page_free_stack_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// after accept: have, want and plan steps, then a test step; a push adds an op step,
// a pop an op and a pop write step, then finish; a stalled result holds the last step until taken
// one item is in work at a time; the next item is taken once the result is registered
// the microcode step counter sets the rate: one control word per cycle
// reset: async active low; clears the step counter, stack pointer, output valid
// and the registers (stash_bytes to 512); stack entries are undefined until pushed
// ----------------------------------------------------------------------------
// bank_page_free_stack_allocator_top
// free page stack allocator driven by a microcoded sequencer
// ----------------------------------------------------------------------------
module bank_page_free_stack_allocator_top #(
  parameter int unsigned MAX_FREE_PAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // new_page, slot_low, slot_mid, slot_top, program_top, new_size
  input  wire logic [63:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_low, out_mid, out_top, vectors_update, free_count, zero pad
  output logic [39:0]      m_axis_tdata,
  // status
  output logic [1:0]       m_axis_tuser
);

  localparam int unsigned AW = (MAX_FREE_PAGES > 1) ? $clog2(MAX_FREE_PAGES) : 1;
  localparam logic [7:0] MaxFree = 8'(MAX_FREE_PAGES);

  logic [7:0] free_pages [MAX_FREE_PAGES];

  logic [2:0]  step_q, step_d;
  logic [7:0]  ptr_q, ptr_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] program_base_q, map_base_q;
  logic [11:0] stash_bytes_q;

  bpfsa_pkg::cmd_e    cmd_q;
  bpfsa_pkg::status_e status_q;
  logic [7:0]  npage_q;
  logic [7:0]  s_q [bpfsa_pkg::Slots];
  logic [15:0] ptop_q, nsize_q, sum_q;
  logic [2:0]  have_q, want_q;
  logic [2:0]  mask_q;
  logic        pop_q, vec_q;
  logic [1:0]  j_q;
  logic [7:0]  rdata_q;
  logic [39:0] out_data_q;
  logic [1:0]  out_user_q;

  bpfsa_pkg::uword_t uw;
  logic        accept, out_free, jump;
  logic [1:0]  j;
  logic [7:0]  push_data;
  logic [7:0]  room;

  bpfsa_pkg::status_e p_status;
  logic [2:0]  p_mask, p_lo, p_hi, fm;
  logic        p_pop, p_vec;
  logic [1:0]  fcnt;
  logic [7:0]  f_mid, f_top;

  assign uw            = bpfsa_pkg::ucode(step_q);
  assign s_axis_tready = (uw.act == bpfsa_pkg::ACT_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign room          = MaxFree - ptr_q;
  assign j             = mask_q[0] ? 2'd0 : (mask_q[1] ? 2'd1 : 2'd2);
  assign push_data     = (cmd_q == bpfsa_pkg::CMD_ADD) ? npage_q : s_q[j];

  // jump condition
  always_comb begin
    case (uw.cond)
      bpfsa_pkg::JC_ALWAYS:    jump = 1'b1;
      bpfsa_pkg::JC_NO_ACCEPT: jump = !accept;
      bpfsa_pkg::JC_DONE:      jump = (status_q != bpfsa_pkg::ST_OK) || (mask_q == 3'd0);
      bpfsa_pkg::JC_PUSH:      jump = !pop_q;
      bpfsa_pkg::JC_OUT_BUSY:  jump = !out_free;
      default:                 jump = 1'b0;
    endcase
    step_d = jump ? uw.target : step_q + 3'd1;
  end

  // command planning: status, slots touched and direction
  always_comb begin
    p_status = bpfsa_pkg::ST_OK;
    p_pop    = 1'b0;
    p_vec    = 1'b0;
    p_lo     = 3'd0;
    p_hi     = 3'd0;
    fm       = {s_q[2] != s_q[1], s_q[1] != s_q[0], 1'b1};
    fcnt     = 2'd1 + {1'b0, fm[1]} + {1'b0, fm[2]};
    p_mask   = 3'd0;
    case (cmd_q)
      bpfsa_pkg::CMD_ADD: begin
        if (room == 8'd0) p_status = bpfsa_pkg::ST_OVER;
        else p_hi = 3'd1;
      end
      bpfsa_pkg::CMD_FREE: begin
        if ({6'd0, fcnt} > room) p_status = bpfsa_pkg::ST_OVER;
      end
      bpfsa_pkg::CMD_ALLOC: begin
        if (have_q > 3'd3) p_status = bpfsa_pkg::ST_TOOBIG;
        else if ({5'd0, have_q} > ptr_q) p_status = bpfsa_pkg::ST_NOPAGE;
        else begin
          p_pop = 1'b1;
          p_hi  = have_q;
        end
      end
      default: begin
        if (have_q > 3'd3 || want_q > 3'd3) p_status = bpfsa_pkg::ST_TOOBIG;
        else if (have_q > want_q) begin
          if ({5'd0, have_q - want_q} > room) p_status = bpfsa_pkg::ST_OVER;
          else begin
            p_lo  = want_q - 3'd1;
            p_hi  = have_q - 3'd1;
            p_vec = (want_q == 3'd1);
          end
        end else if (want_q > have_q) begin
          if ({5'd0, want_q - have_q} > ptr_q) p_status = bpfsa_pkg::ST_NOPAGE;
          else begin
            p_pop = 1'b1;
            p_lo  = have_q - 3'd1;
            p_hi  = want_q - 3'd1;
            p_vec = 1'b1;
          end
        end
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      p_mask[k] = (3'(k) >= p_lo) && (3'(k) < p_hi);
    end
    if (cmd_q == bpfsa_pkg::CMD_FREE && p_status == bpfsa_pkg::ST_OK) p_mask = fm;
  end

  // repeat the last popped page into the slots above an allocation
  always_comb begin
    f_mid = s_q[1];
    f_top = s_q[2];
    if (cmd_q == bpfsa_pkg::CMD_ALLOC && status_q == bpfsa_pkg::ST_OK) begin
      if (have_q < 3'd2) f_mid = s_q[0];
      if (have_q < 3'd3) f_top = f_mid;
    end
  end

  always_comb begin
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (uw.act == bpfsa_pkg::ACT_FINISH && out_free) out_valid_d = 1'b1;
    if (uw.act == bpfsa_pkg::ACT_OP) begin
      ptr_d = pop_q ? ptr_q - 8'd1 : ptr_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= bpfsa_pkg::StepIdle;
      ptr_q          <= 8'd0;
      out_valid_q    <= 1'b0;
      program_base_q <= 16'd0;
      map_base_q     <= 16'd0;
      stash_bytes_q  <= 12'd512;
    end else begin
      step_q      <= step_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bpfsa_pkg::CFG_PROGRAM_BASE: program_base_q <= cfg_data_i;
          bpfsa_pkg::CFG_MAP_BASE:     map_base_q     <= cfg_data_i;
          bpfsa_pkg::CFG_STASH_BYTES:  stash_bytes_q  <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (uw.act)
      bpfsa_pkg::ACT_IDLE: begin
        if (accept) begin
          cmd_q   <= bpfsa_pkg::cmd_e'(s_axis_tuser);
          npage_q <= s_axis_tdata[7:0];
          s_q[0]  <= s_axis_tdata[15:8];
          s_q[1]  <= s_axis_tdata[23:16];
          s_q[2]  <= s_axis_tdata[31:24];
          ptop_q  <= s_axis_tdata[47:32];
          nsize_q <= s_axis_tdata[63:48];
        end
      end
      bpfsa_pkg::ACT_HAVE: begin
        have_q <= bpfsa_pkg::banks_for(ptop_q, stash_bytes_q, program_base_q);
        sum_q  <= nsize_q + map_base_q;
      end
      bpfsa_pkg::ACT_WANT: begin
        want_q <= bpfsa_pkg::banks_for(sum_q, stash_bytes_q, program_base_q);
      end
      bpfsa_pkg::ACT_PLAN: begin
        status_q <= p_status;
        mask_q   <= p_mask;
        pop_q    <= p_pop;
        vec_q    <= p_vec;
      end
      bpfsa_pkg::ACT_OP: begin
        mask_q[j] <= 1'b0;
        j_q       <= j;
        if (pop_q) begin
          rdata_q <= free_pages[ptr_d[AW-1:0]];
        end else begin
          free_pages[ptr_q[AW-1:0]] <= push_data;
          if (cmd_q == bpfsa_pkg::CMD_RESIZE) s_q[j] <= s_q[2];
        end
      end
      bpfsa_pkg::ACT_POPWR: begin
        s_q[j_q] <= rdata_q;
      end
      bpfsa_pkg::ACT_FINISH: begin
        if (out_free) begin
          out_user_q <= status_q;
          out_data_q <= {7'd0, ptr_q, vec_q, f_top, f_mid, s_q[0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

[sv/bpfsa_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpfsa_chk
// port level checks for the page allocator
// ----------------------------------------------------------------------------
module bpfsa_chk #(
  parameter int unsigned MAX_FREE_PAGES = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  localparam logic [7:0] MaxFree = 8'(MAX_FREE_PAGES);

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32:25] <= MaxFree)
    else $error("free count above stack depth");

  a_vec_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != bpfsa_pkg::ST_OK) |-> !m_axis_tdata[24])
    else $error("vector update on failed command");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind bank_page_free_stack_allocator_top bpfsa_chk #(
  .MAX_FREE_PAGES(MAX_FREE_PAGES)
) u_bpfsa_chk (.*);
`default_nettype wire

[tb/bank_page_free_stack_allocator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_page_free_stack_allocator_top_test
// Self-checking bench for the free page stack allocator. A table of directed
// commands comes first: empty and full stack, oversize requests, duplicate
// slots and every resize direction. Random phases follow, one for each
// register setting. Most random items are allocate, free and resize commands
// on maps the block handed out earlier. Results are checked against a local
// stack model or table values; stream sides idle at random but in one phase.
// ----------------------------------------------------------------------------
module bank_page_free_stack_allocator_top_test;

  localparam int MAX_PAGES = 16;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 100;
  localparam int DIR_ROWS  = 23;
  localparam int DRAIN     = 20;

  typedef struct {
    bpfsa_pkg::cmd_e cmd;
    logic [7:0]  page;
    logic [7:0]  s_lo;
    logic [7:0]  s_mid;
    logic [7:0]  s_hi;
    logic [15:0] ptop;
    logic [15:0] nsize;
  } page_cmd_t;

  typedef struct {
    bpfsa_pkg::status_e status;
    logic [7:0] lo;
    logic [7:0] mid;
    logic [7:0] hi;
    logic       vec;
    logic [7:0] fc;
  } map_result_t;

  typedef struct {
    page_cmd_t  c;
    bit         typed;
    bpfsa_pkg::status_e est;
    logic [7:0] efc;
  } dir_row_t;

  typedef struct {
    logic [7:0] lo;
    logic [7:0] mid;
    logic [7:0] hi;
    int         banks;
  } live_map_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  bank_page_free_stack_allocator_top #(
    .MAX_FREE_PAGES(MAX_PAGES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  logic [7:0]  page_stack [MAX_PAGES];
  int          stack_depth;
  logic [15:0] cfg_prog_base;
  logic [15:0] cfg_map_base;
  logic [11:0] cfg_stash;

  map_result_t pending_results [$];
  live_map_t   live_maps [$];
  int          err_count;
  int          checked_count;
  int          sent_count;
  bit          no_idle;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{bpfsa_pkg::CMD_ALLOC,  8'h01, 8'h11, 8'h22, 8'h33, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_NOPAGE, 8'd0},
    '{'{bpfsa_pkg::CMD_ALLOC,  8'h01, 8'h11, 8'h22, 8'h33, 16'hc000, 16'h0000},
      1, bpfsa_pkg::ST_TOOBIG, 8'd0},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h44, 8'h44, 8'h44, 16'h0000, 16'hc000},
      1, bpfsa_pkg::ST_TOOBIG, 8'd0},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h44, 8'h44, 8'h44, 16'h0000, 16'h7000},
      1, bpfsa_pkg::ST_NOPAGE, 8'd0},
    '{'{bpfsa_pkg::CMD_ADD,    8'hff, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OK,     8'd1},
    '{'{bpfsa_pkg::CMD_ADD,    8'h01, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff},
      1, bpfsa_pkg::ST_OK,     8'd2},
    '{'{bpfsa_pkg::CMD_FREE,   8'h01, 8'hff, 8'hff, 8'hff, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OK,     8'd3},
    '{'{bpfsa_pkg::CMD_FREE,   8'h01, 8'h10, 8'h20, 8'h10, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OK,     8'd6},
    '{'{bpfsa_pkg::CMD_FREE,   8'h01, 8'h30, 8'h30, 8'h31, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OK,     8'd8},
    '{'{bpfsa_pkg::CMD_FREE,   8'h01, 8'h32, 8'h33, 8'h34, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OK,     8'd11},
    '{'{bpfsa_pkg::CMD_FREE,   8'h01, 8'h35, 8'h36, 8'h37, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OK,     8'd14},
    '{'{bpfsa_pkg::CMD_FREE,   8'h01, 8'h38, 8'h38, 8'h39, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OK,     8'd16},
    '{'{bpfsa_pkg::CMD_ADD,    8'h80, 8'h01, 8'h02, 8'h03, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OVER,   8'd16},
    '{'{bpfsa_pkg::CMD_FREE,   8'h01, 8'h40, 8'h40, 8'h40, 16'h0000, 16'h0000},
      1, bpfsa_pkg::ST_OVER,   8'd16},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h50, 8'h51, 8'h52, 16'hb000, 16'h0100},
      1, bpfsa_pkg::ST_OVER,   8'd16},
    '{'{bpfsa_pkg::CMD_ALLOC,  8'h01, 8'h00, 8'h00, 8'h00, 16'h7000, 16'h0000},
      0, bpfsa_pkg::ST_OK,     8'd0},
    '{'{bpfsa_pkg::CMD_ALLOC,  8'h01, 8'h00, 8'h00, 8'h00, 16'hb000, 16'h0000},
      0, bpfsa_pkg::ST_OK,     8'd0},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h50, 8'h51, 8'h52, 16'hb000, 16'h0100},
      0, bpfsa_pkg::ST_OK,     8'd0},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h52, 8'h52, 8'h52, 16'h0100, 16'hb000},
      0, bpfsa_pkg::ST_OK,     8'd0},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h60, 8'h61, 8'h61, 16'h4000, 16'h4000},
      0, bpfsa_pkg::ST_OK,     8'd0},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h60, 8'h61, 8'h62, 16'hb000, 16'h7000},
      0, bpfsa_pkg::ST_OK,     8'd0},
    '{'{bpfsa_pkg::CMD_RESIZE, 8'h01, 8'h60, 8'h62, 8'h62, 16'h7000, 16'hb000},
      0, bpfsa_pkg::ST_OK,     8'd0},
    '{'{bpfsa_pkg::CMD_ALLOC,  8'h01, 8'h00, 8'h00, 8'h00, 16'hffff, 16'h0000},
      0, bpfsa_pkg::ST_OK,     8'd0}
  };

  logic [15:0] phase_pb [PHASES] = '{16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000};
  logic [15:0] phase_mb [PHASES] = '{16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h0000};
  logic [11:0] phase_sb [PHASES] = '{12'd512, 12'hfff, 12'h000, 12'hfff, 12'h000, 12'd512};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int bank_count(logic [15:0] addr);
    logic [15:0] v;
    v = addr + {4'd0, cfg_stash} - cfg_prog_base - 16'd1;
    return int'(v[15:14]) + 1;
  endfunction

  // an address that needs exactly n banks under the current registers
  function automatic logic [15:0] top_for(int n);
    logic [15:0] v;
    v = 16'((n - 1) * 16384) + 16'($urandom_range(0, 16383));
    return v + cfg_prog_base + 16'd1 - {4'd0, cfg_stash};
  endfunction

  function automatic map_result_t alloc_predict(page_cmd_t c);
    map_result_t r;
    logic [7:0]  s [3];
    int          n_push;
    int          need;
    int          have;
    int          want;
    r.status = bpfsa_pkg::ST_OK;
    r.vec    = 1'b0;
    s[0] = c.s_lo;
    s[1] = c.s_mid;
    s[2] = c.s_hi;
    case (c.cmd)
      bpfsa_pkg::CMD_ADD: begin
        if (stack_depth >= MAX_PAGES) begin
          r.status = bpfsa_pkg::ST_OVER;
        end else begin
          page_stack[stack_depth] = c.page;
          stack_depth++;
        end
      end
      bpfsa_pkg::CMD_FREE: begin
        n_push = 1;
        if (s[1] != s[0]) n_push++;
        if (s[2] != s[1]) n_push++;
        if (n_push > MAX_PAGES - stack_depth) begin
          r.status = bpfsa_pkg::ST_OVER;
        end else begin
          page_stack[stack_depth] = s[0];
          stack_depth++;
          if (s[1] != s[0]) begin
            page_stack[stack_depth] = s[1];
            stack_depth++;
          end
          if (s[2] != s[1]) begin
            page_stack[stack_depth] = s[2];
            stack_depth++;
          end
        end
      end
      bpfsa_pkg::CMD_ALLOC: begin
        need = bank_count(c.ptop);
        if (need > bpfsa_pkg::Slots) begin
          r.status = bpfsa_pkg::ST_TOOBIG;
        end else if (need > stack_depth) begin
          r.status = bpfsa_pkg::ST_NOPAGE;
        end else begin
          for (int i = 0; i < bpfsa_pkg::Slots; i++) begin
            if (i < need) begin
              stack_depth--;
              s[i] = page_stack[stack_depth];
            end else begin
              s[i] = s[i-1];
            end
          end
        end
      end
      default: begin
        have = bank_count(c.ptop);
        want = bank_count(c.nsize + cfg_map_base);
        if (have > bpfsa_pkg::Slots || want > bpfsa_pkg::Slots) begin
          r.status = bpfsa_pkg::ST_TOOBIG;
        end else if (have > want) begin
          if (have - want > MAX_PAGES - stack_depth) begin
            r.status = bpfsa_pkg::ST_OVER;
          end else begin
            // release banks in ascending slot order, keeping the top slot
            for (int i = want; i < have; i++) begin
              page_stack[stack_depth] = s[i-1];
              stack_depth++;
              s[i-1] = s[2];
            end
            r.vec = (want == 1);
          end
        end else if (want > have) begin
          if (want - have > stack_depth) begin
            r.status = bpfsa_pkg::ST_NOPAGE;
          end else begin
            for (int i = have; i < want; i++) begin
              stack_depth--;
              s[i-1] = page_stack[stack_depth];
            end
            r.vec = 1'b1;
          end
        end
      end
    endcase
    r.lo  = s[0];
    r.mid = s[1];
    r.hi  = s[2];
    r.fc  = 8'(stack_depth);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic send_item(page_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= {c.nsize, c.ptop, c.s_hi, c.s_mid, c.s_lo, c.page};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  initial begin : result_check
    map_result_t e;
    int          stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        checked_count++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", int'(m_axis_tdata[31:0]), 0);
        end else begin
          e = pending_results.pop_front();
          if (m_axis_tuser != e.status) report_mismatch("status", m_axis_tuser, e.status);
          if (m_axis_tdata[7:0] != e.lo) report_mismatch("out_low", m_axis_tdata[7:0], e.lo);
          if (m_axis_tdata[15:8] != e.mid) report_mismatch("out_mid", m_axis_tdata[15:8], e.mid);
          if (m_axis_tdata[23:16] != e.hi) report_mismatch("out_top", m_axis_tdata[23:16], e.hi);
          if (m_axis_tdata[24] != e.vec) report_mismatch("vectors_update", m_axis_tdata[24], e.vec);
          if (m_axis_tdata[32:25] != e.fc) report_mismatch("free_count", m_axis_tdata[32:25], e.fc);
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 18);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    page_cmd_t   c;
    map_result_t res;
    int          sel;
    int          pool_idx;
    int          n_bank;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = bpfsa_pkg::CFG_PROGRAM_BASE;
    cfg_data_i    = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 64'd0;
    s_axis_tuser  = bpfsa_pkg::CMD_ADD;
    stack_depth   = 0;
    cfg_prog_base = 16'd0;
    cfg_map_base  = 16'd0;
    cfg_stash     = 12'd512;
    err_count     = 0;
    checked_count = 0;
    sent_count    = 0;
    no_idle       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_item(dir_tab[k].c);
      res = alloc_predict(dir_tab[k].c);
      if (dir_tab[k].typed) begin
        // failing and stack-only commands echo the slots with no vector update
        res = '{dir_tab[k].est, dir_tab[k].c.s_lo, dir_tab[k].c.s_mid,
                dir_tab[k].c.s_hi, 1'b0, dir_tab[k].efc};
      end
      pending_results.push_back(res);
    end

    for (int p = 0; p < PHASES; p++) begin
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (DRAIN) @(posedge clk_i);
      if (p == PHASES - 1) begin
        phase_pb[p] = 16'($urandom);
        phase_mb[p] = 16'($urandom);
        phase_sb[p] = 12'($urandom);
      end
      no_idle <= (p == 2);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= bpfsa_pkg::CFG_PROGRAM_BASE;
      cfg_data_i <= phase_pb[p];
      @(posedge clk_i);
      cfg_idx_i  <= bpfsa_pkg::CFG_MAP_BASE;
      cfg_data_i <= phase_mb[p];
      @(posedge clk_i);
      cfg_idx_i  <= bpfsa_pkg::CFG_STASH_BYTES;
      cfg_data_i <= {4'd0, phase_sb[p]};
      @(posedge clk_i);
      cfg_we_i      <= 1'b0;
      cfg_prog_base = phase_pb[p];
      cfg_map_base  = phase_mb[p];
      cfg_stash     = phase_sb[p];

      for (int k = 0; k < PHASE_LEN; k++) begin
        pool_idx = -1;
        c.cmd   = bpfsa_pkg::CMD_ADD;
        c.page  = 8'($urandom_range(1, 255));
        c.s_lo  = 8'($urandom);
        c.s_mid = 8'($urandom);
        c.s_hi  = 8'($urandom);
        c.ptop  = 16'($urandom);
        c.nsize = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 15 || (stack_depth < 3 && sel < 45)) begin
          c.cmd = bpfsa_pkg::CMD_ADD;
        end else if (sel < 60 && live_maps.size() > 0) begin
          pool_idx = $urandom_range(0, live_maps.size() - 1);
          c.s_lo  = live_maps[pool_idx].lo;
          c.s_mid = live_maps[pool_idx].mid;
          c.s_hi  = live_maps[pool_idx].hi;
          c.ptop  = top_for(live_maps[pool_idx].banks);
          if (sel < 35) begin
            c.cmd = bpfsa_pkg::CMD_FREE;
          end else begin
            c.cmd   = bpfsa_pkg::CMD_RESIZE;
            c.nsize = top_for(($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3))
                      - cfg_map_base;
          end
        end else if (sel < 88) begin
          c.cmd  = bpfsa_pkg::CMD_ALLOC;
          c.ptop = top_for(($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3));
        end else begin
          c.cmd = bpfsa_pkg::cmd_e'($urandom_range(0, 3));
        end

        send_item(c);
        n_bank = bank_count(c.ptop);
        res = alloc_predict(c);
        pending_results.push_back(res);
        if (res.status == bpfsa_pkg::ST_OK) begin
          if (c.cmd == bpfsa_pkg::CMD_ALLOC && live_maps.size() < 8) begin
            live_maps.push_back(live_map_t'{res.lo, res.mid, res.hi, n_bank});
          end
          if (c.cmd == bpfsa_pkg::CMD_FREE && pool_idx >= 0) begin
            live_maps.delete(pool_idx);
          end
          if (c.cmd == bpfsa_pkg::CMD_RESIZE && pool_idx >= 0) begin
            live_maps[pool_idx] = live_map_t'{res.lo, res.mid, res.hi,
                                              bank_count(c.nsize + cfg_map_base)};
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("%0d commands sent under %0d register settings, %0d results compared",
             sent_count, PHASES + 1, checked_count);
    $display("mismatches found: %0d", err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[bank_page_free_stack_allocator_top.f]
sv/bpfsa_pkg.sv
sv/bank_page_free_stack_allocator_top.sv
sv/bpfsa_chk.sv
tb/bank_page_free_stack_allocator_top_test.sv
